// ----- design/sha384_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-384 package
// Shared types, constants and round functions for the SHA-384 engine.
// ----------------------------------------------------------------------------
package sha384_pkg;

   localparam int unsigned WordWidth    = 64;
   localparam int unsigned BlockWords   = 16;
   localparam int unsigned Rounds       = 80;
   localparam int unsigned DigestWords  = 6;
   localparam int unsigned QueueDepth   = 4;
   localparam int unsigned ByteCntWidth = 61;

   typedef struct packed {
      logic [63:0] message_word;
      logic [3:0]  byte_count;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [63:0] word;
      logic        last_word;
   } blk_word_type;

   localparam logic [63:0] PadWord = 64'h8000000000000000;

   localparam logic [63:0] InitHash [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
      64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
      64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam logic [63:0] RoundConst [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
      ror64 = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] bsig0(input logic [63:0] x);
      bsig0 = ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
   endfunction

   function automatic logic [63:0] bsig1(input logic [63:0] x);
      bsig1 = ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
   endfunction

   function automatic logic [63:0] ssig0(input logic [63:0] x);
      ssig0 = ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] ssig1(input logic [63:0] x);
      ssig1 = ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
   endfunction

endpackage
`default_nettype wire

// ----- design/sha384_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-384 front end
// Accepts message beats, masks the final word, counts bytes and generates
// the padding words and length trailer as a stream of block words.
// ----------------------------------------------------------------------------
module sha384_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  sha384_pkg::req_type       req_data,
   output logic                      out_valid,
   input  wire                       out_ready,
   output sha384_pkg::blk_word_type  out_data
);
   import sha384_pkg::*;

   typedef enum logic [3:0] {
      ST_TAKE = 4'b0001,
      ST_PAD  = 4'b0010,
      ST_ZERO = 4'b0100,
      ST_LEN  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic [ByteCntWidth-1:0]   bytes_ff, bytes_in;
   logic [3:0]                nbytes;
   logic [63:0]               keep_mask;
   logic [63:0]               pad_bit;
   logic [63:0]               masked;

   always_comb begin
      nbytes = (req_data.byte_count > 4'd8) ? 4'd8 : req_data.byte_count;
      keep_mask = ~(64'hFFFFFFFFFFFFFFFF >> {nbytes, 3'b000});
      pad_bit = PadWord >> {nbytes, 3'b000};
      masked = (req_data.message_word & keep_mask) | pad_bit;
   end

   // after the pad word: zero words until slot 15 gets the bit length
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      bytes_in = bytes_ff;
      req_ready = 1'b0;
      out_valid = 1'b0;
      out_data.word = '0;
      out_data.last_word = 1'b0;
      case (state_ff)
         ST_TAKE: begin
            out_valid = req_valid;
            req_ready = out_ready;
            if (req_data.final_word && (nbytes == 4'd8 || nbytes == 4'd0)) begin
               out_data.word = (nbytes == 4'd0) ? PadWord : req_data.message_word;
            end else if (req_data.final_word) begin
               out_data.word = masked;
            end else begin
               out_data.word = req_data.message_word;
            end
            if (req_valid && out_ready) begin
               cnt_in = cnt_ff + 4'd1;
               if (req_data.final_word) begin
                  bytes_in = bytes_ff + ByteCntWidth'(nbytes);
                  if (nbytes == 4'd8) begin
                     state_in = ST_PAD;
                  end else begin
                     state_in = ST_ZERO;
                  end
               end else begin
                  bytes_in = bytes_ff + ByteCntWidth'(8);
               end
            end
         end
         ST_PAD: begin
            out_valid = 1'b1;
            out_data.word = PadWord;
            if (out_ready) begin
               cnt_in = cnt_ff + 4'd1;
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd14) state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            out_valid = 1'b1;
            out_data.word = {bytes_ff, 3'b000};
            out_data.last_word = 1'b1;
            if (out_ready) begin
               cnt_in = '0;
               bytes_in = '0;
               state_in = ST_TAKE;
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         cnt_ff <= '0;
         bytes_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         bytes_ff <= bytes_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/sha384_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-384 word queue
// Small register queue between front end and compression core.
// ----------------------------------------------------------------------------
module sha384_fifo #(
   parameter int unsigned Depth = sha384_pkg::QueueDepth
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  sha384_pkg::blk_word_type  in_data,
   output logic                      out_valid,
   input  wire                       out_ready,
   output sha384_pkg::blk_word_type  out_data
);
   import sha384_pkg::*;

   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   blk_word_type      mem_ff [Depth];
   logic [AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   always_comb begin
      in_ready = (cnt_ff != (AW+1)'(Depth));
      out_valid = (cnt_ff != '0);
      out_data = mem_ff[rp_ff];
      push = in_valid && in_ready;
      pop = out_valid && out_ready;
      wp_in = push ? ((wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = pop ? ((rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule
`default_nettype wire

// ----- design/sha384_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-384 compression core
// Collects 16 words, runs 80 rounds at one per cycle over a 16-word
// schedule window, folds into the hash and emits the digest after the
// length word.
// ----------------------------------------------------------------------------
module sha384_core (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  sha384_pkg::blk_word_type  in_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output sha384_pkg::rsp_type       rsp_data
);
   import sha384_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [63:0]    win_ff [16];
   logic [63:0]    hash_ff [8];
   logic [63:0]    v_ff [8];
   logic [3:0]     cnt_ff, cnt_in;
   logic [6:0]     rnd_ff, rnd_in;
   logic [2:0]     oidx_ff, oidx_in;
   logic           fin_ff, fin_in;
   logic [63:0]    w_new, wt, t1, t2;
   logic           take;

   assign in_ready = (state_ff == ST_LOAD);
   assign take = in_valid && in_ready;

   always_comb begin
      w_new = ssig1(win_ff[14]) + win_ff[9] + ssig0(win_ff[1]) + win_ff[0];
      wt = (rnd_ff < 7'd16) ? win_ff[0] : w_new;
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + RoundConst[rnd_ff] + wt;
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rnd_in = rnd_ff;
      oidx_in = oidx_ff;
      fin_in = fin_ff;
      case (state_ff)
         ST_LOAD: begin
            if (take) begin
               cnt_in = cnt_ff + 4'd1;
               if (in_data.last_word) fin_in = 1'b1;
               if (cnt_ff == 4'd15) begin
                  state_in = ST_ROUND;
                  rnd_in = '0;
               end
            end
         end
         ST_ROUND: begin
            if (rnd_ff == 7'(Rounds - 1)) begin
               rnd_in = '0;
               state_in = ST_FOLD;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end
         ST_FOLD: begin
            oidx_in = '0;
            state_in = fin_ff ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'(DigestWords - 1)) begin
                  state_in = ST_LOAD;
                  fin_in = 1'b0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
         rnd_ff <= '0;
         oidx_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rnd_ff <= rnd_in;
         oidx_ff <= oidx_in;
         fin_ff <= fin_in;
      end
   end

   // window shifts left: new word enters at slot 15
   always_ff @(posedge clock) begin
      if (take || state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= take ? in_data.word : wt;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && take && cnt_ff == 4'd15) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
      end else if (state_ff == ST_FOLD) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
      end else if (state_ff == ST_EMIT && rsp_ready && oidx_ff == 3'(DigestWords - 1)) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
      end
   end

   always_comb begin
      rsp_valid = (state_ff == ST_EMIT);
      rsp_data.digest_word = hash_ff[oidx_ff];
      rsp_data.digest_index = oidx_ff;
      rsp_data.digest_last = (oidx_ff == 3'(DigestWords - 1));
   end

endmodule
`default_nettype wire

// ----- design/sha384_hash_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-384 hash engine
// Streaming SHA-384 over big-endian 64-bit message beats; emits six
// digest beats per message.
// ----------------------------------------------------------------------------
//  channel | ports          | payload
//  input   | req_valid/ready| req_data  (message_word, byte_count, final_word)
//  result  | rsp_valid/ready| rsp_data  (digest_word, digest_index, digest_last)
//
//  Each 16-word block is loaded word by word, then runs 80 rounds on the
//  single round unit and one fold; the core takes no new words meanwhile.
//  Padding completes the final beat's block and may add one more; then 6 result beats.
//  Reset is synchronous; the front keeps taking beats into the queue while it has room
//  and the core runs rounds or waits on rsp_ready.
module sha384_hash_engine #(
   parameter int unsigned QueueDepth = sha384_pkg::QueueDepth
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  sha384_pkg::req_type   req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output sha384_pkg::rsp_type   rsp_data
);
   import sha384_pkg::*;

   blk_word_type f_data, q_data;
   logic         f_valid, f_ready, q_valid, q_ready;

   sha384_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   sha384_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   sha384_core u_core (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

`ifndef SYNTH
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.digest_index <= 3'd5)
      else $error("digest index out of range");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.digest_last == (rsp_data.digest_index == 3'd5)))
      else $error("digest_last mismatch");
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.digest_last |=>
      rsp_valid && rsp_data.digest_index == $past(rsp_data.digest_index) + 3'd1)
      else $error("digest beats not consecutive");
`endif

endmodule
`default_nettype wire

// ----- verif/sha384_hash_engine_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-384 hash engine testbench
// Streams messages of random and corner-case lengths through the engine
// with random idle on both channels, and checks every digest beat against
// a built-in SHA-384 predictor.
// ----------------------------------------------------------------------------
module sha384_hash_engine_tb;
   import sha384_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   sha384_hash_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   localparam logic [63:0] IvWords [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
      64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
      64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam logic [63:0] Kconst [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   // predictor state
   logic [63:0] chain [8];
   logic [63:0] blk [16];
   int unsigned blk_fill;
   logic [60:0] msg_bytes;

   req_type     stim_q [$];
   rsp_type     digest_q [$];
   int unsigned fail_count;
   int unsigned msg_count;
   int unsigned beat_count;
   int unsigned digest_beats;
   logic        drv_quiet;
   logic        mon_quiet;
   logic        stim_done;
   logic        in_taken;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   task automatic chain_init();
      for (int i = 0; i < 8; i++) chain[i] = IvWords[i];
      blk_fill  = 0;
      msg_bytes = '0;
   endtask

   task automatic compress();
      logic [63:0] w [16];
      logic [63:0] v [8];
      logic [63:0] wr, t1, t2, a, b;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            a = w[(r - 2) & 15];
            b = w[(r - 15) & 15];
            wr = (rotr(a, 19) ^ rotr(a, 61) ^ (a >> 6)) + w[(r - 7) & 15]
               + (rotr(b, 1) ^ rotr(b, 8) ^ (b >> 7)) + w[r & 15];
            w[r & 15] = wr;
         end
         t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kconst[r] + wr;
         t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   task automatic load_word(input logic [63:0] w);
      blk[blk_fill] = w;
      blk_fill++;
      if (blk_fill == 16) begin
         compress();
         blk_fill = 0;
      end
   endtask

   task automatic hash_beat(input req_type b);
      int unsigned n;
      logic [63:0] keep;
      rsp_type     r;
      if (!b.final_word) begin
         msg_bytes = msg_bytes + 61'd8;
         load_word(b.message_word);
         return;
      end
      n = (b.byte_count > 8) ? 8 : b.byte_count;
      msg_bytes = msg_bytes + 61'(n);
      if (n == 0) begin
         load_word(PadWord);
      end else if (n == 8) begin
         load_word(b.message_word);
         load_word(PadWord);
      end else begin
         keep = ~64'd0 << (64 - 8 * n);
         load_word((b.message_word & keep) | (64'h80 << (56 - 8 * n)));
      end
      if (blk_fill > 14) load_word('0);
      while (blk_fill < 14) load_word('0);
      load_word('0);
      load_word({msg_bytes, 3'b000});
      for (int k = 0; k < 6; k++) begin
         r.digest_word  = chain[k];
         r.digest_index = 3'(k);
         r.digest_last  = (k == 5);
         digest_q.push_back(r);
      end
      msg_count++;
      chain_init();
   endtask

   function automatic logic [63:0] rand64();
      rand64 = {$urandom(), $urandom()};
   endfunction

   task automatic add_beat(input logic [63:0] w, input int unsigned bc, input logic fin);
      req_type b;
      b.message_word = w;
      b.byte_count   = 4'(bc);
      b.final_word   = fin;
      stim_q.push_back(b);
   endtask

   // nonfinal beats carry a random (ignored) byte count
   task automatic add_message(input int unsigned full_words, input int unsigned tail_bytes);
      for (int i = 0; i < full_words; i++) add_beat(rand64(), $urandom_range(15), 1'b0);
      add_beat(rand64(), tail_bytes, 1'b1);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("sha384_hash_engine verification failed");
      $finish;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_taken) begin
         if (in_taken) void'(stim_q.pop_front());
         if (stim_q.size() > 0 && (drv_quiet || $urandom_range(99) >= 22)) begin
            req_valid <= 1'b1;
            req_data  <= stim_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (!reset) rsp_ready <= mon_quiet || ($urandom_range(99) >= 22);
   end

   // monitor
   always @(posedge clock) begin
      in_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         hash_beat(req_data);
         beat_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         digest_beats++;
         if (digest_q.size() == 0) begin
            $error("unexpected digest beat %h", rsp_data.digest_word);
            fail_count++;
         end else begin
            if (rsp_data.digest_word !== digest_q[0].digest_word) begin
               $error("digest_word exp %h got %h", digest_q[0].digest_word,
                      rsp_data.digest_word);
               fail_count++;
            end
            if (rsp_data.digest_index !== digest_q[0].digest_index) begin
               $error("digest_index exp %0d got %0d", digest_q[0].digest_index,
                      rsp_data.digest_index);
               fail_count++;
            end
            if (rsp_data.digest_last !== digest_q[0].digest_last) begin
               $error("digest_last exp %0d got %0d", digest_q[0].digest_last,
                      rsp_data.digest_last);
               fail_count++;
            end
            void'(digest_q.pop_front());
         end
      end
   end

   initial begin
      int unsigned guard;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      fail_count = 0;
      msg_count  = 0;
      beat_count = 0;
      digest_beats = 0;
      drv_quiet  = 1'b0;
      mon_quiet  = 1'b0;
      chain_init();
      // directed: empty, every tail length, oversize counts, block boundaries
      add_beat('0, 0, 1'b1);
      add_beat('1, 0, 1'b1);
      for (int n = 1; n <= 8; n++) add_beat('1, n, 1'b1);
      add_beat('1, 15, 1'b1);
      add_beat(64'h0123456789abcdef, 9, 1'b1);
      add_message(14, 8);
      add_message(13, 7);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      add_message(15, 0);
      add_message(16, 3);
      // random messages, mostly short
      while (stim_q.size() < 520) begin
         if ($urandom_range(9) == 0) add_message($urandom_range(40), $urandom_range(15));
         else add_message($urandom_range(20), $urandom_range(8));
      end
      // no-idle stretch in the middle of the run
      wait (stim_q.size() < 300);
      drv_quiet = 1'b1;
      mon_quiet = 1'b1;
      wait (stim_q.size() < 150);
      drv_quiet = 1'b0;
      mon_quiet = 1'b0;
      wait (stim_q.size() == 0);
      guard = 0;
      while (digest_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
      $display("covered %0d beats in %0d messages, %0d digest beats checked",
               beat_count, msg_count, digest_beats);
      if (fail_count == 0 && digest_q.size() == 0) begin
         $display("sha384_hash_engine verification clean");
      end else begin
         $display("sha384_hash_engine verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/sha384_pkg.sv
design/sha384_front.sv
design/sha384_fifo.sv
design/sha384_core.sv
design/sha384_hash_engine.sv
verif/sha384_hash_engine_tb.sv
